// ===== hdl/arpc_pkg.sv =====
// arpc_pkg: types, codes and sizes shared by the address-resolution cache.
// No dependencies.
`timescale 1ns / 1ps
package arpc_pkg;

	localparam int CACHE_ENTRIES = 64;
	localparam int PENDING_SLOTS = 8;
	localparam int CW = $clog2(CACHE_ENTRIES);
	localparam int PW = $clog2(PENDING_SLOTS);

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_QUEUE  = 2'd2;
	localparam logic [1:0] ACT_TICK   = 2'd3;

	localparam logic [2:0] KIND_LOOKUP = 3'd0;
	localparam logic [2:0] KIND_INSERT = 3'd1;
	localparam logic [2:0] KIND_QUEUED = 3'd2;
	localparam logic [2:0] KIND_SEND   = 3'd3;
	localparam logic [2:0] KIND_UNREACH = 3'd4;
	localparam logic [2:0] KIND_IDLE   = 3'd5;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_RETRY   = 2'd1;
	localparam logic [1:0] REG_GAP     = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] ip;
		logic [47:0] mac;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] ip_out;
		logic [47:0] mac_out;
		logic        hit;
		logic        full_res;
		logic        last;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [7:0]  age;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CSCAN, ST_PSCAN, ST_EMIT, ST_CLEAR
	} state_t;

endpackage

// ===== hdl/arp_cache_with_request_retry.sv =====
// Top level of the address-resolution cache with request retry.
// Depends on arpc_pkg; cache table held in one synchronous memory.
//
// channel  | valid     | ready     | payload
// request  | in_valid  | in_ready  | in_data  (req_t)
// result   | out_valid | out_ready | out_data (res_t)
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// The block accepts a request, walks the 64-entry cache memory (one read port,
// registered read), walks the 8 pending slots and loads the final result before it
// takes another. Tick results wait in a one-deep hold register so the final one can
// carry last. After reset a clearing pass zeroes the 64-entry cache memory; no request
// is taken then. A stalled result holds the pending-slot walk of a tick in place.
`timescale 1ns / 1ps
module arp_cache_with_request_retry
	import arpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output res_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	entry_t mem [CACHE_ENTRIES];
	entry_t rd_q;

	logic [7:0] timeout_q, gap_q;
	logic [3:0] retry_q;

	logic        pvalid_q [PENDING_SLOTS];
	logic [31:0] pip_q    [PENDING_SLOTS];
	logic [3:0]  ptries_q [PENDING_SLOTS];
	logic [7:0]  page_q   [PENDING_SLOTS];

	state_t state_q, state_d;
	req_t   req_q;
	logic [CW:0] idx_q;
	logic [CW:0] wb_q;
	logic        wb_v_q;
	logic [PW:0] pidx_q;
	logic        found_q, free_q;
	logic [47:0] fmac_q;
	logic [CW-1:0] fslot_q;
	logic        phit_q;
	logic        hold_v_q;
	res_t        hold_q;
	logic        out_v_q;
	res_t        out_q;

	entry_t upd;
	logic   wr_en;
	logic [CW-1:0] wr_addr;
	entry_t wr_data;
	logic [CW-1:0] rd_addr;
	logic   scan_done;
	logic   out_free;

	logic [PW-1:0] pslot;
	logic [PW-1:0] pw_slot;
	logic [PW-1:0] qslot;
	logic          qfree;
	logic          pw_en;
	logic          pw_valid;
	logic [31:0]   pw_ip;
	logic [3:0]    pw_tries;
	logic [7:0]    pw_age;
	logic [7:0]    page_inc;
	logic          pdue;
	res_t          tick_res;
	logic          ld_out;
	res_t          ld_data;

	assign out_free  = !out_v_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign rd_addr   = idx_q[CW-1:0];
	assign scan_done = wb_v_q && (wb_q == (CW+1)'(CACHE_ENTRIES - 1));
	assign pslot     = pidx_q[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 8'd15;
			retry_q   <= 4'd5;
			gap_q     <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_RETRY:   retry_q   <= cfg_data[3:0];
				REG_GAP:     gap_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick update of the entry read last cycle
	always_comb begin
		upd = rd_q;
		if (upd.age != 8'hff) upd.age = upd.age + 8'd1;
		if (upd.valid && upd.age > timeout_q) upd.valid = 1'b0;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wb_q[CW-1:0];
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = idx_q[CW-1:0];
		end else if (state_q == ST_CSCAN && wb_v_q && req_q.action == ACT_TICK) begin
			wr_en = 1'b1;
			wr_data = upd;
		end else if (state_q == ST_PSCAN && req_q.action == ACT_INSERT && pidx_q == '0
				&& free_q) begin
			wr_en = 1'b1;
			wr_addr = fslot_q;
			wr_data = '{valid: 1'b1, ip: req_q.ip, mac: req_q.mac, age: 8'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// pending table: one slot update a cycle
	always_comb begin
		pw_en    = 1'b0;
		pw_slot  = pslot;
		pw_valid = 1'b0;
		pw_ip    = '0;
		pw_tries = '0;
		pw_age   = 8'hff;
		pdue     = 1'b0;
		tick_res = '0;
		page_inc = page_q[pslot];
		if (page_inc != 8'hff) page_inc = page_inc + 8'd1;
		qfree = 1'b0;
		qslot = '0;
		for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
			if (!pvalid_q[i]) begin
				qfree = 1'b1;
				qslot = PW'(i);
			end
		end
		if (state_q == ST_PSCAN && pidx_q != (PW+1)'(PENDING_SLOTS)) begin
			if (req_q.action == ACT_TICK) begin
				if (out_free && pvalid_q[pslot]) begin
					pw_en    = 1'b1;
					pw_valid = 1'b1;
					pw_ip    = pip_q[pslot];
					pw_tries = ptries_q[pslot];
					pw_age   = page_inc;
					if (page_inc > gap_q) begin
						pdue = 1'b1;
						tick_res.ip_out = pip_q[pslot];
						if (ptries_q[pslot] < retry_q) begin
							tick_res.kind = KIND_SEND;
							pw_tries = ptries_q[pslot] + 4'd1;
							pw_age = 8'd0;
						end else begin
							tick_res.kind = KIND_UNREACH;
							pw_valid = 1'b0;
							pw_ip = '0;
							pw_tries = '0;
							pw_age = 8'hff;
						end
					end
				end
			end else if (req_q.action == ACT_INSERT && pvalid_q[pslot]
					&& pip_q[pslot] == req_q.ip && !phit_q) begin
				pw_en = 1'b1;
			end
		end else if (state_q == ST_EMIT && out_free && req_q.action == ACT_QUEUE
				&& !phit_q && qfree) begin
			pw_en    = 1'b1;
			pw_slot  = qslot;
			pw_valid = 1'b1;
			pw_ip    = req_q.ip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PENDING_SLOTS; i++) begin
				pvalid_q[i] <= 1'b0;
				pip_q[i] <= '0;
				ptries_q[i] <= '0;
				page_q[i] <= 8'hff;
			end
		end else if (pw_en) begin
			pvalid_q[pw_slot] <= pw_valid;
			pip_q[pw_slot] <= pw_ip;
			ptries_q[pw_slot] <= pw_tries;
			page_q[pw_slot] <= pw_age;
		end
	end

	always_comb begin
		ld_out  = 1'b0;
		ld_data = '0;
		if (state_q == ST_PSCAN && pdue && hold_v_q) begin
			ld_out  = 1'b1;
			ld_data = hold_q;
		end else if (state_q == ST_EMIT && out_free) begin
			ld_out = 1'b1;
			ld_data.last = 1'b1;
			ld_data.ip_out = req_q.ip;
			unique case (req_q.action)
				ACT_LOOKUP: begin
					ld_data.kind = KIND_LOOKUP;
					ld_data.hit = found_q;
					ld_data.mac_out = found_q ? fmac_q : '0;
				end
				ACT_INSERT: begin
					ld_data.kind = KIND_INSERT;
					ld_data.hit = phit_q;
					ld_data.full_res = !free_q;
				end
				ACT_QUEUE: begin
					ld_data.kind = KIND_QUEUED;
					ld_data.hit = phit_q;
					ld_data.full_res = !phit_q && !qfree;
				end
				ACT_TICK: begin
					// release the held result as the final one
					if (hold_v_q) begin
						ld_data = hold_q;
						ld_data.last = 1'b1;
					end else begin
						ld_data.kind = KIND_IDLE;
						ld_data.ip_out = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else if (ld_out) begin
			out_v_q <= 1'b1;
			out_q   <= ld_data;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (idx_q == (CW+1)'(CACHE_ENTRIES - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid && in_ready) state_d = ST_CSCAN;
			ST_CSCAN: if (scan_done) state_d = ST_PSCAN;
			ST_PSCAN: if (pidx_q == (PW+1)'(PENDING_SLOTS)) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			req_q    <= '0;
			idx_q    <= '0;
			wb_q     <= '0;
			wb_v_q   <= 1'b0;
			pidx_q   <= '0;
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			fmac_q   <= '0;
			fslot_q  <= '0;
			phit_q   <= 1'b0;
			hold_v_q <= 1'b0;
			hold_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: idx_q <= idx_q + 1'b1;
				ST_IDLE: if (in_valid && in_ready) begin
					req_q <= in_data;
					idx_q <= '0;
					wb_v_q <= 1'b0;
					found_q <= 1'b0;
					free_q <= 1'b0;
					fmac_q <= '0;
					phit_q <= 1'b0;
					hold_v_q <= 1'b0;
					pidx_q <= '0;
				end
				ST_CSCAN: begin
					if (idx_q != (CW+1)'(CACHE_ENTRIES)) idx_q <= idx_q + 1'b1;
					wb_q <= idx_q;
					wb_v_q <= (idx_q != (CW+1)'(CACHE_ENTRIES));
					if (wb_v_q) begin
						if (rd_q.valid && rd_q.ip == req_q.ip) begin
							found_q <= 1'b1;
							fmac_q <= rd_q.mac;
						end
						if (!rd_q.valid && !free_q) begin
							free_q <= 1'b1;
							fslot_q <= wb_q[CW-1:0];
						end
					end
				end
				ST_PSCAN: if (pidx_q != (PW+1)'(PENDING_SLOTS)) begin
					if (req_q.action == ACT_TICK) begin
						if (out_free) begin
							pidx_q <= pidx_q + 1'b1;
							if (pdue) begin
								hold_q <= tick_res;
								hold_v_q <= 1'b1;
							end
						end
					end else begin
						pidx_q <= pidx_q + 1'b1;
						if (pvalid_q[pslot] && pip_q[pslot] == req_q.ip) phit_q <= 1'b1;
					end
				end
				ST_EMIT: ;
				default: ;
			endcase
		end
	end

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready) else $error("request taken during clear");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !(in_valid && in_ready)) else $error("overlap");

endmodule
